FILE: hdl/histogram_bin_accumulate_unit_macros.svh
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_BIN_ACCUMULATE_UNIT_MACROS_SVH
`define HISTOGRAM_BIN_ACCUMULATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram unit check failed");

// Next-cycle implication, disabled while reset is asserted
`define HBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram unit check failed");

`endif

FILE: hdl/hba_pkg.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - package
// Sizes, operation and status codes, register map and shared types.
// ---------------------------------------------------------------------------
package hba_pkg;

  // Storage sizes
  localparam int NUM_BINS  = 64;
  localparam int NUM_EDGES = NUM_BINS + 1;
  localparam int EDGE_AW   = $clog2(NUM_EDGES);
  localparam int CNT_AW    = $clog2(NUM_BINS);
  localparam int BIN_W     = $clog2(NUM_BINS + 1);

  // Field widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 7;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 48;

  // Config port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int BIU_W     = 7;
  localparam int MODE_W    = 2;
  localparam logic REG_BINS_IN_USE = 1'b0;
  localparam logic REG_RANGE_MODE  = 1'b1;
  localparam logic [BIU_W-1:0] RST_BINS_IN_USE = 7'd64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_BIN   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_EDGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd3;

  // Range modes
  localparam logic [MODE_W-1:0] MODE_IGNORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUEEZE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERROR   = 2'd2;

  // Special bin index below the first edge
  localparam logic [IDX_W-1:0] IDX_BELOW = {IDX_W{1'b1}};

  // Count saturation limits
  localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [BIU_W-1:0]  bins_in_use;
    logic [MODE_W-1:0] range_mode;
  } cfg_t;

endpackage

FILE: hdl/histogram_bin_accumulate_unit.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - top level
// Add sample: busy for two range checks, one search step per cycle (up to log2
// of the active bins, one edge RAM read each) and one count update; a range miss
// ends at its check unless in squeeze mode; strobe follows. Add/read bin: busy
// for the count update; bad index, edge write, clear, other ops: strobe next cycle.
// Synchronous reset: all bins and edges read as zero, bins_in_use 64, mode 0.
// ---------------------------------------------------------------------------
module histogram_bin_accumulate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [hba_pkg::OP_W-1:0]            in_op,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_sample,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_weight,
  input  logic [hba_pkg::SLOT_W-1:0]          in_slot,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_edge_value,
  // Result channel
  output logic                                out_valid,
  output logic signed [hba_pkg::IDX_W-1:0]    out_bin_index,
  output logic [hba_pkg::STATUS_W-1:0]        out_status,
  output logic signed [hba_pkg::CNT_W-1:0]    out_count,
  // Config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hba_pkg::APB_AW-1:0]          paddr,
  input  logic [hba_pkg::APB_DW-1:0]          pwdata,
  output logic [hba_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  hba_pkg::cfg_t cfg;

  // Register file
  hba_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Search and update engine
  hba_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_sample     (in_sample),
    .in_weight     (in_weight),
    .in_slot       (in_slot),
    .in_edge_value (in_edge_value),
    .out_valid     (out_valid),
    .out_bin_index (out_bin_index),
    .out_status    (out_status),
    .out_count     (out_count)
  );

endmodule

FILE: hdl/hba_ram.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/hba_alu.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - shared adder
// One 49-bit add/subtract: edge compare during search, count update after.
// ---------------------------------------------------------------------------
module hba_alu (
  input  logic signed [hba_pkg::CNT_W-1:0]  a,
  input  logic signed [hba_pkg::DATA_W:0]   b,
  input  logic                              sub,
  output logic signed [hba_pkg::CNT_W:0]    sum
);

  logic signed [hba_pkg::CNT_W:0] a_x;
  logic signed [hba_pkg::CNT_W:0] b_x;

  // Sign-extend both operands to the full sum width
  assign a_x = {a[hba_pkg::CNT_W-1], a};
  assign b_x = {{(hba_pkg::CNT_W - hba_pkg::DATA_W){b[hba_pkg::DATA_W]}}, b};

  assign sum = sub ? (a_x - b_x) : (a_x + b_x);

endmodule

FILE: hdl/hba_cfg.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - configuration registers
// APB-style register file: bins_in_use at 0x0, range_mode at 0x4.
// ---------------------------------------------------------------------------
module hba_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hba_pkg::APB_AW-1:0]  paddr,
  input  logic [hba_pkg::APB_DW-1:0]  pwdata,
  output logic [hba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output hba_pkg::cfg_t               cfg
);

  logic [hba_pkg::BIU_W-1:0]  bins_r;
  logic [hba_pkg::BIU_W-1:0]  bins_nxt;
  logic [hba_pkg::MODE_W-1:0] mode_r;
  logic [hba_pkg::MODE_W-1:0] mode_nxt;
  logic                       wr_hit;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[hba_pkg::APB_AW-1];

  // Register write decode
  always_comb begin
    bins_nxt = bins_r;
    mode_nxt = mode_r;
    if (wr_hit) begin
      if (reg_sel == hba_pkg::REG_BINS_IN_USE) begin
        bins_nxt = pwdata[hba_pkg::BIU_W-1:0];
      end else begin
        mode_nxt = pwdata[hba_pkg::MODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= hba_pkg::RST_BINS_IN_USE;
      mode_r <= hba_pkg::MODE_IGNORE;
    end else begin
      bins_r <= bins_nxt;
      mode_r <= mode_nxt;
    end
  end

  // Read-back mux
  always_comb begin
    if (reg_sel == hba_pkg::REG_BINS_IN_USE) begin
      prdata = hba_pkg::APB_DW'(bins_r);
    end else begin
      prdata = hba_pkg::APB_DW'(mode_r);
    end
  end

  assign cfg.bins_in_use = bins_r;
  assign cfg.range_mode  = mode_r;

endmodule

FILE: hdl/hba_seq.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - sequencer
// Binary search over the edge RAM and read-modify-write of the count RAM,
// both through one shared adder, stepped by a small state machine.
// ---------------------------------------------------------------------------
module hba_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hba_pkg::cfg_t                       cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic [hba_pkg::OP_W-1:0]            in_op,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_sample,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_weight,
  input  logic [hba_pkg::SLOT_W-1:0]          in_slot,
  input  logic signed [hba_pkg::DATA_W-1:0]   in_edge_value,
  output logic                                out_valid,
  output logic signed [hba_pkg::IDX_W-1:0]    out_bin_index,
  output logic [hba_pkg::STATUS_W-1:0]        out_status,
  output logic signed [hba_pkg::CNT_W-1:0]    out_count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LO   = 5'b00010,
    S_HI   = 5'b00100,
    S_MID  = 5'b01000,
    S_CNT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [hba_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [hba_pkg::DATA_W-1:0]   sample_r, sample_nxt;
  logic [hba_pkg::DATA_W-1:0]   weight_r, weight_nxt;
  logic [hba_pkg::BIN_W-1:0]    b_r, b_nxt;
  logic [hba_pkg::EDGE_AW-1:0]  lo_r, lo_nxt;
  logic [hba_pkg::EDGE_AW-1:0]  hi_r, hi_nxt;
  logic [hba_pkg::EDGE_AW-1:0]  addr_r, addr_nxt;
  logic [hba_pkg::CNT_AW-1:0]   cnt_addr_r, cnt_addr_nxt;
  logic [hba_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [hba_pkg::NUM_EDGES-1:0] edge_vld_r, edge_vld_nxt;
  logic [hba_pkg::NUM_BINS-1:0]  cnt_vld_r, cnt_vld_nxt;
  logic                         edge_rd_vld_r;
  logic                         cnt_rd_vld_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [hba_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [hba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [hba_pkg::CNT_W-1:0]    out_count_r, out_count_nxt;

  logic                         edge_we;
  logic                         cnt_we;
  logic [hba_pkg::DATA_W-1:0]   edge_rdata;
  logic [hba_pkg::CNT_W-1:0]    cnt_rdata;
  logic [hba_pkg::DATA_W-1:0]   edge_eff;
  logic [hba_pkg::CNT_W-1:0]    cnt_eff;
  logic [hba_pkg::CNT_W-1:0]    cnt_sat;

  logic signed [hba_pkg::CNT_W-1:0] alu_a;
  logic signed [hba_pkg::DATA_W:0]  alu_b;
  logic                             alu_sub;
  logic signed [hba_pkg::CNT_W:0]   alu_sum;
  logic                             sample_ge;

  logic [hba_pkg::BIN_W-1:0]    b_act;
  logic [hba_pkg::BIN_W-1:0]    b_last;
  logic [hba_pkg::EDGE_AW-1:0]  step_lo;
  logic [hba_pkg::EDGE_AW-1:0]  step_hi;
  logic [hba_pkg::EDGE_AW-1:0]  step_span;
  logic [hba_pkg::EDGE_AW:0]    step_sum;
  logic                         oor;
  logic                         oor_below;

  // Active bin count: zero acts as one, large values clamp to the array size
  always_comb begin
    if (cfg.bins_in_use == '0) begin
      b_act = hba_pkg::BIN_W'(1);
    end else if (hba_pkg::BIN_W'(cfg.bins_in_use) > hba_pkg::BIN_W'(hba_pkg::NUM_BINS)) begin
      b_act = hba_pkg::BIN_W'(hba_pkg::NUM_BINS);
    end else begin
      b_act = hba_pkg::BIN_W'(cfg.bins_in_use);
    end
  end

  assign b_last = b_r - hba_pkg::BIN_W'(1);

  // Entries never written since reset read as zero; counts also since a clear
  assign edge_eff = edge_rd_vld_r ? edge_rdata : '0;
  assign cnt_eff  = cnt_rd_vld_r  ? cnt_rdata  : '0;

  // Shared adder: sample - edge while searching, count + weight on update
  assign alu_sub = (state_r != S_CNT);
  assign alu_a   = (state_r == S_CNT) ? cnt_eff
                 : {{(hba_pkg::CNT_W - hba_pkg::DATA_W){sample_r[hba_pkg::DATA_W-1]}},
                    sample_r};
  assign alu_b   = (state_r == S_CNT) ? {weight_r[hba_pkg::DATA_W-1], weight_r}
                                      : {edge_eff[hba_pkg::DATA_W-1], edge_eff};

  hba_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign sample_ge = !alu_sum[hba_pkg::CNT_W];

  // Saturate the 49-bit sum back into 48 bits
  always_comb begin
    if (alu_sum[hba_pkg::CNT_W] != alu_sum[hba_pkg::CNT_W-1]) begin
      cnt_sat = alu_sum[hba_pkg::CNT_W] ? hba_pkg::CNT_MIN : hba_pkg::CNT_MAX;
    end else begin
      cnt_sat = alu_sum[hba_pkg::CNT_W-1:0];
    end
  end

  // Search step: narrow the interval by the current compare
  assign step_lo   = sample_ge ? addr_r : lo_r;
  assign step_hi   = sample_ge ? hi_r   : addr_r;
  assign step_span = step_hi - step_lo;
  assign step_sum  = {1'b0, step_lo} + {1'b0, step_hi};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    sample_nxt     = sample_r;
    weight_nxt     = weight_r;
    b_nxt          = b_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    addr_nxt       = addr_r;
    cnt_addr_nxt   = cnt_addr_r;
    idx_nxt        = idx_r;
    edge_vld_nxt   = edge_vld_r;
    cnt_vld_nxt    = cnt_vld_r;
    edge_we        = 1'b0;
    cnt_we         = 1'b0;
    oor            = 1'b0;
    oor_below      = 1'b0;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          sample_nxt = in_sample;
          weight_nxt = in_weight;
          b_nxt      = b_act;
          idx_nxt    = hba_pkg::IDX_W'(in_slot);
          case (in_op)
            hba_pkg::OP_ADD_SAMPLE: begin
              addr_nxt  = '0;
              state_nxt = S_LO;
            end
            hba_pkg::OP_ADD_BIN, hba_pkg::OP_READ_BIN: begin
              if (hba_pkg::BIN_W'(in_slot) >= b_act ||
                  in_slot > hba_pkg::SLOT_W'(hba_pkg::NUM_BINS)) begin
                out_valid_nxt  = 1'b1;
                out_idx_nxt    = hba_pkg::IDX_W'(in_slot);
                out_status_nxt = hba_pkg::ST_BAD_IDX;
                out_count_nxt  = '0;
              end else begin
                cnt_addr_nxt = in_slot[hba_pkg::CNT_AW-1:0];
                state_nxt    = S_CNT;
              end
            end
            hba_pkg::OP_WRITE_EDGE: begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = hba_pkg::IDX_W'(in_slot);
              out_count_nxt = '0;
              if (in_slot > hba_pkg::SLOT_W'(hba_pkg::NUM_BINS)) begin
                out_status_nxt = hba_pkg::ST_BAD_IDX;
              end else begin
                edge_we = 1'b1;
                edge_vld_nxt[in_slot[hba_pkg::EDGE_AW-1:0]] = 1'b1;
                out_status_nxt = hba_pkg::ST_OK;
              end
            end
            hba_pkg::OP_CLEAR: begin
              cnt_vld_nxt    = '0;
              out_valid_nxt  = 1'b1;
              out_idx_nxt    = '0;
              out_status_nxt = hba_pkg::ST_OK;
              out_count_nxt  = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_idx_nxt    = '0;
              out_status_nxt = hba_pkg::ST_OK;
              out_count_nxt  = '0;
            end
          endcase
        end
      end

      // Compare against the first edge
      S_LO: begin
        if (!sample_ge) begin
          oor       = 1'b1;
          oor_below = 1'b1;
        end else begin
          addr_nxt  = hba_pkg::EDGE_AW'(b_r);
          state_nxt = S_HI;
        end
      end

      // Compare against the last active edge, then seed the search
      S_HI: begin
        if (sample_ge) begin
          oor = 1'b1;
        end else if (b_r > hba_pkg::BIN_W'(1)) begin
          lo_nxt    = '0;
          hi_nxt    = hba_pkg::EDGE_AW'(b_r);
          addr_nxt  = hba_pkg::EDGE_AW'(b_r >> 1);
          state_nxt = S_MID;
        end else begin
          idx_nxt      = '0;
          cnt_addr_nxt = '0;
          state_nxt    = S_CNT;
        end
      end

      // One binary search step per cycle
      S_MID: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_span > hba_pkg::EDGE_AW'(1)) begin
          addr_nxt = step_sum[hba_pkg::EDGE_AW:1];
        end else begin
          idx_nxt      = hba_pkg::IDX_W'(step_lo);
          cnt_addr_nxt = step_lo[hba_pkg::CNT_AW-1:0];
          state_nxt    = S_CNT;
        end
      end

      // Count read data is here: update or return it
      S_CNT: begin
        out_valid_nxt  = 1'b1;
        out_idx_nxt    = idx_r;
        out_status_nxt = hba_pkg::ST_OK;
        if (op_r == hba_pkg::OP_READ_BIN) begin
          out_count_nxt = cnt_eff;
        end else begin
          cnt_we                  = 1'b1;
          cnt_vld_nxt[cnt_addr_r] = 1'b1;
          out_count_nxt           = cnt_sat;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Sample outside the active edges
    if (oor) begin
      if (cfg.range_mode == hba_pkg::MODE_SQUEEZE) begin
        if (oor_below) begin
          idx_nxt      = '0;
          cnt_addr_nxt = '0;
        end else begin
          idx_nxt      = hba_pkg::IDX_W'(b_last);
          cnt_addr_nxt = b_last[hba_pkg::CNT_AW-1:0];
        end
        state_nxt = S_CNT;
      end else begin
        out_valid_nxt  = 1'b1;
        out_idx_nxt    = oor_below ? hba_pkg::IDX_BELOW : hba_pkg::IDX_W'(b_r);
        out_status_nxt = (cfg.range_mode == hba_pkg::MODE_ERROR) ? hba_pkg::ST_ERROR
                                                                 : hba_pkg::ST_IGNORED;
        out_count_nxt  = '0;
        state_nxt      = S_IDLE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_vld_r  <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_vld_r  <= edge_vld_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers; read valid follows the address sent to each RAM
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    sample_r      <= sample_nxt;
    weight_r      <= weight_nxt;
    b_r           <= b_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    addr_r        <= addr_nxt;
    cnt_addr_r    <= cnt_addr_nxt;
    idx_r         <= idx_nxt;
    edge_rd_vld_r <= edge_vld_r[addr_nxt];
    cnt_rd_vld_r  <= cnt_vld_r[cnt_addr_nxt];
    out_idx_r     <= out_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Edge storage
  hba_ram #(
    .WIDTH (hba_pkg::DATA_W),
    .DEPTH (hba_pkg::NUM_EDGES)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_we),
    .wr_addr (in_slot[hba_pkg::EDGE_AW-1:0]),
    .wr_data (in_edge_value),
    .rd_addr (addr_nxt),
    .rd_data (edge_rdata)
  );

  // Bin count storage
  hba_ram #(
    .WIDTH (hba_pkg::CNT_W),
    .DEPTH (hba_pkg::NUM_BINS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_addr_r),
    .wr_data (cnt_sat),
    .rd_addr (cnt_addr_nxt),
    .rd_data (cnt_rdata)
  );

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_bin_index = out_idx_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;

endmodule

FILE: hdl/hba_checker.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - port checker
// Port-level properties of the item and result channels, bound to the top.
// ---------------------------------------------------------------------------
`include "histogram_bin_accumulate_unit_macros.svh"

module hba_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [hba_pkg::OP_W-1:0]            in_op,
  input logic                                out_valid,
  input logic signed [hba_pkg::IDX_W-1:0]    out_bin_index,
  input logic [hba_pkg::STATUS_W-1:0]        out_status,
  input logic signed [hba_pkg::CNT_W-1:0]    out_count
);

  // Any non-ok status carries a zero count
  `HBA_ASSERT_IMP(a_status_zero_count, out_valid && (out_status != hba_pkg::ST_OK), out_count == '0)

  // Clear answers in the next cycle with an all-zero result
  `HBA_ASSERT_NXT(a_clear_result, start && !busy && (in_op == hba_pkg::OP_CLEAR), out_valid && (out_count == '0) && (out_status == hba_pkg::ST_OK) && (out_bin_index == '0))

  // A result strobe only appears once the engine is free again
  `HBA_ASSERT_IMP(a_strobe_not_busy, out_valid, !busy)

  // The engine only goes busy because an item was taken
  `HBA_ASSERT_IMP(a_busy_from_item, $rose(busy), $past(start && !busy))

endmodule

bind histogram_bin_accumulate_unit hba_checker u_hba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_bin_index (out_bin_index),
  .out_status    (out_status),
  .out_count     (out_count)
);

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// Histogram bin accumulate unit - testbench
// Drives command items and APB register writes into the unit and predicts
// each result from a private copy of the bins, edges and registers. Results
// are checked field by field in order; a directed opening, a long
// saturation run and randomized phases over several register settings
// exercise the edge search, range modes, index checks and clamping.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hba_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;

  // Register map: byte address 4*i
  localparam logic [APB_AW-1:0] ADDR_BINS = {REG_BINS_IN_USE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MODE = {REG_RANGE_MODE, 2'b00};

  localparam longint COUNT_TOP    = (longint'(1) <<< (CNT_W - 1)) - 1;
  localparam longint COUNT_BOTTOM = -COUNT_TOP - 1;
  localparam int     S32_MAX      = 32'sh7fffffff;
  localparam int     S32_MIN      = 32'sh80000000;
  localparam int     SAT_RUN      = 65540;
  localparam int     CYCLE_LIMIT  = 2500000;
  localparam int     NUM_PHASES   = 10;
  localparam int     PHASE_ITEMS  = 150;

  typedef enum {EDGES_UNIFORM, EDGES_SORTED, EDGES_FULL_SPAN, EDGES_SCRAMBLED} edge_plan_e;

  typedef struct {
    logic [IDX_W-1:0]    bin_index;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } hist_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: histogram predictor and queue of expected results
  // -------------------------------------------------------------------------
  class hist_scoreboard;
    longint           bin_val[NUM_BINS];
    int               edge_val[NUM_EDGES];
    logic [BIU_W-1:0] bins_reg;
    logic [MODE_W-1:0] mode_reg;
    hist_result_t     expected_q[$];
    int               errors;

    function new();
      foreach (bin_val[i]) bin_val[i] = 0;
      foreach (edge_val[i]) edge_val[i] = 0;
      bins_reg = RST_BINS_IN_USE;
      mode_reg = MODE_IGNORE;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // zero acts as one, oversize clamps to the storage
    function int active_bins();
      int b;
      b = bins_reg;
      if (b == 0) b = 1;
      if (b > NUM_BINS) b = NUM_BINS;
      return b;
    endfunction

    function void set_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == ADDR_BINS) bins_reg = data[BIU_W-1:0];
      else if (addr == ADDR_MODE) mode_reg = data[MODE_W-1:0];
    endfunction

    // fixed binary search over edges 0..b
    function int find_bin(int x, int b);
      int lo, hi, mid;
      lo = 0;
      hi = b;
      if (x < edge_val[0]) return -1;
      if (x >= edge_val[b]) return b;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (edge_val[mid] <= x) lo = mid;
        else hi = mid;
      end
      return lo;
    endfunction

    function longint clamp_add(longint c, int w);
      longint s;
      s = c + longint'(w);
      if (s > COUNT_TOP) s = COUNT_TOP;
      if (s < COUNT_BOTTOM) s = COUNT_BOTTOM;
      return s;
    endfunction

    // accepted item: update state, queue its result
    function void note_item(logic [OP_W-1:0] op, int sample, int weight,
                            logic [SLOT_W-1:0] slot, int edge_v);
      int b, idx;
      logic [STATUS_W-1:0] st;
      longint cnt;
      bit skip;
      hist_result_t r;
      b = active_bins();
      idx = 0;
      st = ST_OK;
      cnt = 0;
      skip = 0;
      case (op)
        OP_ADD_SAMPLE: begin
          idx = find_bin(sample, b);
          if (idx < 0 || idx >= b) begin
            if (mode_reg == MODE_SQUEEZE) begin
              idx = (idx < 0) ? 0 : b - 1;
            end else begin
              st = (mode_reg == MODE_ERROR) ? ST_ERROR : ST_IGNORED;
              skip = 1;
            end
          end
          if (!skip) begin
            bin_val[idx] = clamp_add(bin_val[idx], weight);
            cnt = bin_val[idx];
          end
        end
        OP_ADD_BIN: begin
          idx = slot;
          if (idx >= b) begin
            st = ST_BAD_IDX;
          end else begin
            bin_val[idx] = clamp_add(bin_val[idx], weight);
            cnt = bin_val[idx];
          end
        end
        OP_READ_BIN: begin
          idx = slot;
          if (idx >= b) st = ST_BAD_IDX;
          else cnt = bin_val[idx];
        end
        OP_WRITE_EDGE: begin
          idx = slot;
          if (idx > NUM_BINS) st = ST_BAD_IDX;
          else edge_val[idx] = edge_v;
        end
        OP_CLEAR: begin
          foreach (bin_val[i]) bin_val[i] = 0;
        end
        default: ;
      endcase
      r.bin_index = idx[IDX_W-1:0];
      r.status = st;
      r.count = cnt[CNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void flag(string what, longint exp_v, longint got_v);
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_result(logic [IDX_W-1:0] bi, logic [STATUS_W-1:0] st,
                               logic [CNT_W-1:0] cnt);
      hist_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected result, expected none, actual bin %0d status %0d count %0d",
                   $time, $signed(bi), st, $signed(cnt));
        return;
      end
      r = expected_q.pop_front();
      if (bi !== r.bin_index)
        flag("bin_index", longint'($signed(r.bin_index)), longint'($signed(bi)));
      if (st !== r.status)
        flag("status", longint'(r.status), longint'(st));
      if (cnt !== r.count)
        flag("count", longint'($signed(r.count)), longint'($signed(cnt)));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Signals and DUT
  // -------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          in_op;
  logic signed [DATA_W-1:0] in_sample;
  logic signed [DATA_W-1:0] in_weight;
  logic [SLOT_W-1:0]        in_slot;
  logic signed [DATA_W-1:0] in_edge_value;
  logic                     out_valid;
  logic signed [IDX_W-1:0]  out_bin_index;
  logic [STATUS_W-1:0]      out_status;
  logic signed [CNT_W-1:0]  out_count;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  hist_scoreboard sb;
  bit             no_gaps;
  int             cycles;

  histogram_bin_accumulate_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_op(in_op), .in_sample(in_sample), .in_weight(in_weight),
    .in_slot(in_slot), .in_edge_value(in_edge_value),
    .out_valid(out_valid), .out_bin_index(out_bin_index),
    .out_status(out_status), .out_count(out_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("histogram_bin_accumulate_unit verification failed");
      $finish;
    end
  end

  // Monitor: check results first, then note the item accepted this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_bin_index, out_status, out_count);
      if (start && !busy)
        sb.note_item(in_op, in_sample, in_weight, in_slot, in_edge_value);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic int clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return int'(v);
  endfunction

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(1, 1000);
      2: return -int'($urandom_range(1, 1000));
      3: return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // samples aimed mostly inside the active edge span
  function automatic int rand_sample();
    int b, lo, hi, r;
    longint span;
    b = sb.active_bins();
    lo = sb.edge_val[0];
    hi = sb.edge_val[b];
    r = $urandom_range(0, 99);
    if (r < 55 && lo <= hi) begin
      span = longint'(hi) - longint'(lo) + 1;
      return int'(longint'(lo) + longint'($urandom) % span);
    end
    if (r < 75)
      return clamp32(longint'(sb.edge_val[$urandom_range(0, b)]) +
                     longint'($urandom_range(0, 2)) - 1);
    if (r < 85) return clamp32(longint'(lo) - longint'($urandom_range(1, 1000)));
    if (r < 92) return clamp32(longint'(hi) + longint'($urandom_range(0, 1000)));
    return $urandom;
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot(int b);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, b - 1);
    return $urandom_range(0, (1 << SLOT_W) - 1);
  endfunction

  // one item, held until accepted; called and returns at a falling edge
  task automatic send_item(logic [OP_W-1:0] op, int sample, int weight,
                           logic [SLOT_W-1:0] slot, int edge_v);
    int g;
    in_op = op;
    in_sample = sample;
    in_weight = weight;
    in_slot = slot;
    in_edge_value = edge_v;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    g = pick_gap();
    if (g > 0) begin
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    wait_idle();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(addr, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // program edges 0..B for the current bin count
  task automatic load_edges(edge_plan_e plan);
    int b, e;
    longint v, step;
    b = sb.active_bins();
    v = $signed($urandom) >>> 8;
    step = $urandom_range(1, 1 << 18);
    if (plan == EDGES_SORTED) v = $signed($urandom) >>> 2;
    if (plan == EDGES_FULL_SPAN) begin
      v = S32_MIN;
      step = (longint'(S32_MAX) - longint'(S32_MIN)) / b;
    end
    for (int i = 0; i <= b; i++) begin
      case (plan)
        EDGES_UNIFORM:   e = clamp32(v + i * step);
        EDGES_FULL_SPAN: e = (i == b) ? S32_MAX : clamp32(v + i * step);
        EDGES_SORTED: begin
          e = clamp32(v);
          if ($urandom_range(0, 3) != 0) v += $urandom_range(1, 1 << 22);
        end
        default:         e = $urandom;
      endcase
      send_item(OP_WRITE_EDGE, $urandom, $urandom, i[SLOT_W-1:0], e);
    end
  endtask

  // random mix over the current setting
  task automatic run_phase(int n);
    int b, r, i;
    for (int k = 0; k < n; k++) begin
      b = sb.active_bins();
      r = $urandom_range(0, 99);
      if (r < 58) begin
        send_item(OP_ADD_SAMPLE, rand_sample(), rand_weight(), $urandom, $urandom);
      end else if (r < 70) begin
        send_item(OP_ADD_BIN, $urandom, rand_weight(), rand_slot(b), $urandom);
      end else if (r < 82) begin
        send_item(OP_READ_BIN, $urandom, $urandom, rand_slot(b), $urandom);
      end else if (r < 88) begin
        // edge rewrite: near the old value, or noise
        i = $urandom_range(0, b);
        if ($urandom_range(0, 1) != 0)
          send_item(OP_WRITE_EDGE, $urandom, $urandom, i[SLOT_W-1:0],
                    clamp32(longint'(sb.edge_val[i]) + longint'($urandom_range(0, 64)) - 32));
        else
          send_item(OP_WRITE_EDGE, $urandom, $urandom,
                    $urandom_range(0, (1 << SLOT_W) - 1), $urandom);
      end else if (r < 91) begin
        send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 94) begin
        send_item($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST), $urandom, $urandom,
                  $urandom, $urandom);
      end else begin
        send_item(OP_ADD_SAMPLE, $urandom, rand_weight(), $urandom, $urandom);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  int               phase_bins[NUM_PHASES] = '{64, 1, 0, 127, 7, 33, 64, 2, 100, 5};
  logic [MODE_W-1:0] phase_mode[NUM_PHASES] = '{MODE_IGNORE, MODE_SQUEEZE, MODE_ERROR,
      MODE_SPARE, MODE_SQUEEZE, MODE_ERROR, MODE_SQUEEZE, MODE_IGNORE, MODE_ERROR,
      MODE_SQUEEZE};
  edge_plan_e       phase_plan[NUM_PHASES] = '{EDGES_UNIFORM, EDGES_SORTED, EDGES_FULL_SPAN,
      EDGES_SORTED, EDGES_UNIFORM, EDGES_FULL_SPAN, EDGES_SCRAMBLED, EDGES_SORTED,
      EDGES_UNIFORM, EDGES_SORTED};

  initial begin
    sb = new();
    no_gaps = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_ADD_SAMPLE;
    in_sample = '0;
    in_weight = '0;
    in_slot = '0;
    in_edge_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset state, index limits, weight extremes, all-zero edges
    send_item(OP_READ_BIN, 0, 0, 7'd0, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd63, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd64, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd127, 0);
    send_item(OP_ADD_SAMPLE, 0, 1, 7'd0, 0);
    send_item(OP_ADD_SAMPLE, -1, 1, 7'd0, 0);
    send_item(OP_ADD_BIN, 0, S32_MAX, 7'd0, 0);
    send_item(OP_ADD_BIN, 0, S32_MIN, 7'd0, 0);
    send_item(OP_ADD_BIN, 0, -5, 7'd63, 0);
    send_item(OP_ADD_BIN, 0, 9, 7'd64, 0);
    send_item(OP_ADD_BIN, 0, 9, 7'd127, 0);
    send_item(OP_WRITE_EDGE, 0, 0, 7'd0, S32_MIN);
    send_item(OP_WRITE_EDGE, 0, 0, 7'd64, S32_MAX);
    send_item(OP_WRITE_EDGE, 0, 0, 7'd65, 32'h1234_5678);
    send_item(OP_WRITE_EDGE, 0, 0, 7'd127, -1);
    send_item(OP_ADD_SAMPLE, S32_MIN, 3, 7'd0, 0);
    send_item(OP_ADD_SAMPLE, S32_MAX, 3, 7'd0, 0);
    send_item(OP_ADD_SAMPLE, 0, 3, 7'd0, 0);
    send_item(OP_CLEAR, 0, 0, 7'd0, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd0, 0);
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
      send_item(o[OP_W-1:0], $urandom, $urandom, $urandom, $urandom);
    // below and above range under squeeze and error modes
    send_item(OP_WRITE_EDGE, 0, 0, 7'd0, 5 << 16);
    cfg_write(ADDR_MODE, {30'd0, MODE_SQUEEZE});
    send_item(OP_ADD_SAMPLE, 0, 11, 7'd0, 0);
    send_item(OP_ADD_SAMPLE, S32_MAX, 12, 7'd0, 0);
    cfg_write(ADDR_MODE, {30'd0, MODE_ERROR});
    send_item(OP_ADD_SAMPLE, 0, 13, 7'd0, 0);
    send_item(OP_ADD_SAMPLE, S32_MAX, 14, 7'd0, 0);

    // Saturation at both ends of the count range, back to back
    cfg_write(ADDR_BINS, 32'd2);
    no_gaps = 1'b1;
    send_item(OP_CLEAR, 0, 0, 7'd0, 0);
    repeat (SAT_RUN) send_item(OP_ADD_BIN, 0, S32_MAX, 7'd0, 0);
    repeat (SAT_RUN) send_item(OP_ADD_BIN, 0, S32_MIN, 7'd1, 0);
    send_item(OP_ADD_BIN, 0, S32_MIN, 7'd0, 0);
    send_item(OP_ADD_BIN, 0, S32_MAX, 7'd1, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd0, 0);
    send_item(OP_READ_BIN, 0, 0, 7'd1, 0);
    no_gaps = 1'b0;

    // Random phases over register settings; upper data bits are don't-care
    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(ADDR_BINS, ($urandom & ~32'h7f) | phase_bins[p]);
      cfg_write(ADDR_MODE, ($urandom & ~32'h3) | phase_mode[p]);
      no_gaps = (p % 4 == 3);
      load_edges(phase_plan[p]);
      run_phase(PHASE_ITEMS);
    end

    // Drain and finish
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("histogram_bin_accumulate_unit verification clean");
    end else begin
      $display("histogram_bin_accumulate_unit verification failed");
    end
    $finish;
  end

endmodule
